@@ src/npis_pkg.sv @@
// Package with shared types and constants for the nearest point index search block.
`default_nettype none

package npis_pkg;

    // Default table depth and coordinate width
    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed widths of the result fields
    localparam int INDEX_OUT_W = 10;
    localparam int DIST_OUT_W  = 33;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Tag that travels with each table read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

@@ src/nearest_point_index_search.sv @@
// Clear and append never raise busy; a query of a non-empty table holds busy through
// the scan and the pipeline drain, and strobes its result once the last point leaves the pipeline.
// An empty-table query strobes found=0 in the next cycle with busy never raised.
// Throughput is set by the single table read port: one stored point per cycle.
// Reset empties the table count and clears control; the receiver cannot stall.
// Top level: controller, best-match tracking and result register.
`default_nettype none

module nearest_point_index_search
    import npis_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             op,
    input  wire logic [COORD_WIDTH-1:0] point_x,
    input  wire logic [COORD_WIDTH-1:0] point_y,
    output logic                        done,
    output logic      [INDEX_OUT_W-1:0] nearest_index,
    output logic      [DIST_OUT_W-1:0]  nearest_distance,
    output logic                        found
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = (2 * COORD_WIDTH + 1 > 64) ? 64 : 2 * COORD_WIDTH + 1;

    state_t state_reg, state_next;

    logic                   accept;
    logic                   is_clear, is_append, is_query;
    logic                   wr_en;
    logic                   scan_en;
    logic                   scan_last;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [COORD_WIDTH-1:0] query_x_reg, query_y_reg;
    logic [2*COORD_WIDTH-1:0] rd_data;

    tag_t                   issue_tag;
    tag_t                   pipe_tag;
    logic [IDX_W-1:0]       pipe_idx;
    logic [DIST_W-1:0]      pipe_dist;

    logic                   first_reg, first_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]      best_dist_reg, best_dist_next;
    logic                   take;

    logic                   done_reg, done_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic [DIST_W-1:0]      res_dist_reg, res_dist_next;
    logic [31:0]            idx_wide;
    logic [63:0]            dist_wide;

    // Decode the request
    assign accept = start && !busy;

    always_comb
    begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_query  = 1'b0;
        unique case (op_t'(op))
            OP_CLEAR:  is_clear  = 1'b1;
            OP_APPEND: is_append = 1'b1;
            OP_QUERY:  is_query  = 1'b1;
            default:   ;
        endcase
    end

    assign wr_en     = accept && is_append && (count_reg < CNT_W'(MAX_POINTS));
    assign scan_last = (scan_cnt_reg == count_reg - CNT_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_tag.valid && pipe_tag.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        busy    = 1'b1;
        scan_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy    = 1'b0;
            ST_SCAN:  scan_en = 1'b1;
            ST_DRAIN: ;
            default:  ;
        endcase
    end

    assign issue_tag.valid = scan_en;
    assign issue_tag.last  = scan_en && scan_last;

    // Update the point count and scan counter
    always_comb
    begin
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        if (accept && is_clear)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (accept && is_query)
        begin
            scan_cnt_next = '0;
        end
        else if (scan_en)
        begin
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end
    end

    // Track the best match; only a strictly smaller distance replaces it
    assign take = first_reg || (pipe_dist < best_dist_reg);

    always_comb
    begin
        first_next     = first_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (accept && is_query)
        begin
            first_next = 1'b1;
        end
        else if (pipe_tag.valid)
        begin
            first_next = 1'b0;
            if (take)
            begin
                best_idx_next  = pipe_idx;
                best_dist_next = pipe_dist;
            end
        end
    end

    // Load the result register
    always_comb
    begin
        done_next     = 1'b0;
        found_next    = found_reg;
        res_idx_next  = res_idx_reg;
        res_dist_next = res_dist_reg;
        if (accept && is_query && (count_reg == '0))
        begin
            done_next     = 1'b1;
            found_next    = 1'b0;
            res_idx_next  = '0;
            res_dist_next = '0;
        end
        else if (pipe_tag.valid && pipe_tag.last)
        begin
            done_next     = 1'b1;
            found_next    = 1'b1;
            res_idx_next  = best_idx_next;
            res_dist_next = best_dist_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            first_reg    <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            first_reg    <= first_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            query_x_reg <= point_x;
            query_y_reg <= point_y;
        end
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        res_idx_reg   <= res_idx_next;
        res_dist_reg  <= res_dist_next;
    end

    npis_point_mem #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W),
        .DATA_W (2 * COORD_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data ({point_y, point_x}),
        .rd_en   (scan_en),
        .rd_addr (scan_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    npis_dist_pipe #(
        .CW     (COORD_WIDTH),
        .IDX_W  (IDX_W),
        .DIST_W (DIST_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .issue_idx (scan_cnt_reg[IDX_W-1:0]),
        .rd_data   (rd_data),
        .query_x   (query_x_reg),
        .query_y   (query_y_reg),
        .out_tag   (pipe_tag),
        .out_idx   (pipe_idx),
        .out_dist  (pipe_dist)
    );

    // Drive the result ports
    assign idx_wide         = 32'(res_idx_reg);
    assign dist_wide        = 64'(res_dist_reg);
    assign done             = done_reg;
    assign found            = found_reg;
    assign nearest_index    = idx_wide[INDEX_OUT_W-1:0];
    assign nearest_distance = dist_wide[DIST_OUT_W-1:0];

`ifndef ASSERT_OFF
    // Table writes never overlap a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE))
        else $error("append write during scan");

    // Scan address stays inside the filled part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg < count_reg))
        else $error("scan beyond point count");

    // Pipeline output only appears while a query is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_tag.valid |-> (state_reg != ST_IDLE))
        else $error("distance pipeline active while idle");

    // A found index refers to a stored point
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (CNT_W'(res_idx_reg) < count_reg))
        else $error("result index outside table");
`endif

endmodule

`default_nettype wire

@@ src/npis_point_mem.sv @@
// Point table memory: one write port, one registered read port.
`default_nettype none

module npis_point_mem
    import npis_pkg::*;
#(
    parameter int DEPTH  = MAX_POINTS_DEF,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 2 * COORD_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Store an appended point
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry per cycle during a scan
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/npis_dist_pipe.sv @@
// Squared distance pipeline: align read data, absolute differences, squares, sum.
`default_nettype none

module npis_dist_pipe
    import npis_pkg::*;
#(
    parameter int CW     = COORD_WIDTH_DEF,
    parameter int IDX_W  = 10,
    parameter int DIST_W = 2 * COORD_WIDTH_DEF + 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tag_t              issue_tag,
    input  wire logic [IDX_W-1:0]  issue_idx,
    input  wire logic [2*CW-1:0]   rd_data,
    input  wire logic [CW-1:0]     query_x,
    input  wire logic [CW-1:0]     query_y,
    output tag_t                   out_tag,
    output logic      [IDX_W-1:0]  out_idx,
    output logic      [DIST_W-1:0] out_dist
);

    tag_t              tag0_reg, tag1_reg, tag2_reg, tag3_reg;
    logic [IDX_W-1:0]  idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic [CW-1:0]     store_x, store_y;
    logic [CW-1:0]     dx_next, dy_next, dx_reg, dy_reg;
    logic [2*CW-1:0]   sqx_reg, sqy_reg;
    logic [2*CW:0]     sum_full;
    logic [DIST_W-1:0] dist_reg;

    // Advance the tags alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag0_reg <= issue_tag;
            tag1_reg <= tag0_reg;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Take the absolute coordinate differences
    assign store_x = rd_data[CW-1:0];
    assign store_y = rd_data[2*CW-1:CW];
    assign dx_next = (query_x >= store_x) ? (query_x - store_x) : (store_x - query_x);
    assign dy_next = (query_y >= store_y) ? (query_y - store_y) : (store_y - query_y);

    // Add the squares; the sum wraps at the distance width
    assign sum_full = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Payload stages
    always_ff @(posedge clk)
    begin
        idx0_reg <= issue_idx;
        idx1_reg <= idx0_reg;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        idx2_reg <= idx1_reg;
        sqx_reg  <= (2*CW)'(dx_reg) * (2*CW)'(dx_reg);
        sqy_reg  <= (2*CW)'(dy_reg) * (2*CW)'(dy_reg);
        idx3_reg <= idx2_reg;
        dist_reg <= sum_full[DIST_W-1:0];
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_dist = dist_reg;

endmodule

`default_nettype wire
